>>> rtl/rglf_pkg.sv
// Shared constants and types of the rank-gated low-pass filter.
`default_nettype none
package rglf_pkg;

   localparam int WINDOW_DEF   = 40;
   localparam int CHANNELS_DEF = 3;

   localparam int CHANNEL_W = 2;
   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 16;
   localparam int FILT_W    = 32;
   localparam int FRAC_XTRA = 16;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd328;

   // control from the sequencer to the rank counter
   typedef struct packed {
      logic clear;
      logic compare;
   } rank_ctl_type;

endpackage
`default_nettype wire

>>> rtl/rank_gated_lowpass_filter_core.sv
// Top level: sequencer, per-channel state and result register of the filter.
//
// Requests (req_channel, req_temp_sample) enter on a valid/ready channel;
// each gives exactly one response (rsp_filtered_temp, rsp_accepted).
// The sample is written into the channel's ring window, then every window
// entry is read back from the sample RAM, one per cycle, and ranked against
// the sample; a middle-quartile sample moves the filter state by gain times
// the difference. The scan is paced by the single RAM read port feeding
// one comparator; a new request is taken only after the response of the
// last one has been written to the output register.
// A request naming a channel at or above CHANNELS goes straight to the
// response state, answers zero and leaves windows and filter states alone.
// One request is in work at a time; req_ready is high only when idle.
// The response sits in an output register: a new request is taken while
// it waits, and the next result waits until rsp_ready frees that register.
// After reset all CHANNELS * WINDOW (120 by default) sample RAM entries
// are cleared, with req_ready low. csr_filter_gain is taken whenever
// csr_valid is high and must only change while no request is in work.
`default_nettype none
module rank_gated_lowpass_filter_core
   import rglf_pkg::*;
#(
   parameter int WINDOW   = WINDOW_DEF,
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic        [CHANNEL_W-1:0] req_channel,
   input  wire logic signed [SAMPLE_W-1:0]  req_temp_sample,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic      signed [SAMPLE_W-1:0]  rsp_filtered_temp,
   output logic                            rsp_accepted,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic        [GAIN_W-1:0]    csr_filter_gain
);

   localparam int DEPTH = CHANNELS * WINDOW;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(WINDOW);
   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_WRITE = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic [AW-1:0]              clr_addr_ff, clr_addr_in;
   logic [CH_W-1:0]            ch_ff, ch_in;
   logic                       ch_ok_ff, ch_ok_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [AW-1:0]              base_ff, base_in;
   logic [PW-1:0]              pos_ff, pos_in;
   logic [PW-1:0]              idx_ff, idx_in;
   logic                       rd_pend_ff, rd_pend_in;
   logic [GAIN_W-1:0]          gain_ff, gain_in;
   logic [PW-1:0]              wp_ff [CHANNELS];
   logic signed [FILT_W-1:0]   filt_ff [CHANNELS];
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic                       rsp_acc_ff, rsp_acc_in;

   logic [CH_W-1:0]            req_ch_idx;
   logic                       req_ch_ok;
   logic                       req_fire;
   logic [PW-1:0]              cur_pos;
   logic                       ram_we;
   logic [AW-1:0]              ram_waddr;
   logic [SAMPLE_W-1:0]        ram_wdata;
   logic [AW-1:0]              ram_raddr;
   logic [SAMPLE_W-1:0]        ram_rdata;
   rank_ctl_type               rank_ctl;
   logic                       mid_ok;
   logic signed [FILT_W-1:0]   filt_cur;
   logic signed [FILT_W-1:0]   filt_new;
   logic                       upd_ok;
   logic                       fin_go;

   assign req_ch_idx = CH_W'(req_channel);
   assign req_ch_ok  = 32'(req_channel) < CHANNELS;
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign cur_pos  = req_ch_ok ? wp_ff[req_ch_idx] : '0;
   assign filt_cur = ch_ok_ff ? filt_ff[ch_ff] : '0;
   assign upd_ok   = ch_ok_ff && mid_ok;
   assign fin_go   = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      ch_in        = ch_ff;
      ch_ok_in     = ch_ok_ff;
      sample_in    = sample_ff;
      base_in      = base_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      rd_pend_in   = 1'b0;
      gain_in      = csr_valid ? csr_filter_gain : gain_ff;
      rank_ctl     = '{clear: 1'b0, compare: rd_pend_ff};
      ram_we       = 1'b0;
      ram_waddr    = base_ff + AW'(pos_ff);
      ram_wdata    = sample_ff;
      ram_raddr    = base_ff + AW'(idx_ff);
      case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               ch_in         = req_ch_idx;
               ch_ok_in      = req_ch_ok;
               sample_in     = req_temp_sample;
               base_in       = AW'(req_ch_idx * WINDOW);
               pos_in        = (cur_pos == PW'(WINDOW - 1)) ? '0 : cur_pos + PW'(1);
               idx_in        = '0;
               rank_ctl.clear = 1'b1;
               state_in      = req_ch_ok ? ST_WRITE : ST_FIN;
            end
         end
         ST_WRITE: begin
            ram_we   = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rd_pend_in = 1'b1;
            idx_in     = idx_ff + PW'(1);
            if (idx_ff == PW'(WINDOW - 1)) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (fin_go) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_temp_in  = rsp_temp_ff;
      rsp_acc_in   = rsp_acc_ff;
      if (fin_go) begin
         rsp_valid_in = 1'b1;
         rsp_acc_in   = upd_ok;
         rsp_temp_in  = upd_ok ? filt_new[FILT_W-1:FRAC_XTRA]
                               : filt_cur[FILT_W-1:FRAC_XTRA];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         gain_ff      <= GAIN_RESET;
         rsp_valid_ff <= 1'b0;
         ch_ok_ff     <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            wp_ff[i]   <= '0;
            filt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_pend_ff   <= rd_pend_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
         ch_ok_ff     <= ch_ok_in;
         if (req_fire && req_ch_ok) begin
            wp_ff[req_ch_idx] <= pos_in;
         end
         if (fin_go && upd_ok) begin
            filt_ff[ch_ff] <= filt_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      sample_ff   <= sample_in;
      base_ff     <= base_in;
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      rsp_temp_ff <= rsp_temp_in;
      rsp_acc_ff  <= rsp_acc_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filtered_temp = rsp_temp_ff;
   assign rsp_accepted      = rsp_acc_ff;

   rglf_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(DEPTH)
   ) u_window_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   rglf_rank #(
      .WINDOW(WINDOW)
   ) u_rank (
      .clock  (clock),
      .reset  (reset),
      .ctl    (rank_ctl),
      .rd_data($signed(ram_rdata)),
      .sample (sample_ff),
      .mid_ok (mid_ok)
   );

   rglf_update u_update (
      .clock   (clock),
      .load    (state_ff == ST_MUL),
      .filt_in (filt_cur),
      .sample  (sample_ff),
      .gain    (gain_ff),
      .filt_out(filt_new)
   );

endmodule
`default_nettype wire

>>> rtl/rglf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rglf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 120
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/rglf_rank.sv
// Rank counter: one window entry compared against the new sample per cycle.
`default_nettype none
module rglf_rank
   import rglf_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire rank_ctl_type               ctl,
   input  wire logic signed [SAMPLE_W-1:0] rd_data,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   output logic                            mid_ok
);

   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int RANK_LIMIT = (WINDOW / 4) * 3;

   logic [CNT_W-1:0] above_ff, above_in;
   logic [CNT_W-1:0] below_ff, below_in;

   always_comb begin
      above_in = above_ff;
      below_in = below_ff;
      if (ctl.clear) begin
         above_in = '0;
         below_in = '0;
      end else if (ctl.compare) begin
         if (rd_data > sample) above_in = above_ff + CNT_W'(1);
         if (rd_data < sample) below_in = below_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff <= '0;
         below_ff <= '0;
      end else begin
         above_ff <= above_in;
         below_ff <= below_in;
      end
   end

   assign mid_ok = (above_ff < CNT_W'(RANK_LIMIT)) && (below_ff < CNT_W'(RANK_LIMIT));

endmodule
`default_nettype wire

>>> rtl/rglf_update.sv
// Filter update: registered gain product, then subtract from the state.
`default_nettype none
module rglf_update
   import rglf_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       load,
   input  wire logic signed [FILT_W-1:0]   filt_in,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   input  wire logic        [GAIN_W-1:0]   gain,
   output logic      signed [FILT_W-1:0]   filt_out
);

   localparam int D_W    = FILT_W + 1;
   localparam int P_W    = D_W + GAIN_W + 1;
   localparam int STEP_W = P_W - FRAC_XTRA;

   logic signed [FILT_W-1:0] target;
   logic signed [D_W-1:0]    diff;
   logic signed [GAIN_W:0]   gain_s;
   logic signed [P_W-1:0]    prod_ff, prod_in;
   logic signed [STEP_W-1:0] step;
   logic signed [STEP_W-1:0] next_val;

   always_comb begin
      target   = {sample, {FRAC_XTRA{1'b0}}};
      diff     = D_W'(filt_in) - D_W'(target);
      gain_s   = $signed({1'b0, gain});
      prod_in  = diff * gain_s;
      // arithmetic shift gives floor division by 2^16
      step     = $signed(prod_ff[P_W-1:FRAC_XTRA]);
      next_val = STEP_W'(filt_in) - step;
      filt_out = next_val[FILT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/rglf_check.sv
// Port-level checker for the filter core, bound to the top level.
`default_nettype none
module rglf_check
   import rglf_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic signed [SAMPLE_W-1:0] rsp_filtered_temp,
   input wire logic                       rsp_accepted
);

   // a stalled response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered_temp)
                                  && $stable(rsp_accepted))
      else $error("response changed while stalled");

   // one request in work at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a response only appears at the end of work
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without a request in work");

   // reset empties the output and starts the RAM clear
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("bad state after reset");

endmodule

bind rank_gated_lowpass_filter_core rglf_check u_rglf_check (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_filtered_temp(rsp_filtered_temp),
   .rsp_accepted     (rsp_accepted)
);
`default_nettype wire

>>> dv/rglf_result_checker.sv
// Checker for the rank-gated low-pass filter: predicts each response and compares it.
module rglf_result_checker
   import rglf_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire logic        [CHANNEL_W-1:0] req_channel,
   input  wire logic signed [SAMPLE_W-1:0]  req_temp_sample,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic signed [SAMPLE_W-1:0]  rsp_filtered_temp,
   input  wire logic                       rsp_accepted,
   input  wire logic                       csr_valid,
   input  wire logic                       csr_ready,
   input  wire logic        [GAIN_W-1:0]    csr_filter_gain,
   output int                              fail_count,
   output int                              pending
);

   localparam int RANK_LIMIT = (WINDOW_DEF / 4) * 3;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered_temp;
      logic                       accepted;
   } filt_result_type;

   logic signed [SAMPLE_W-1:0] win_mem [CHANNELS_DEF][WINDOW_DEF];
   int                         wr_pos [CHANNELS_DEF];
   logic signed [FILT_W-1:0]   filt_state [CHANNELS_DEF];
   logic        [GAIN_W-1:0]   gain_copy;
   filt_result_type            expected_q [$];
   filt_result_type            want;
   int                         rsp_count;

   initial begin
      fail_count = 0;
      pending    = 0;
      rsp_count  = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      $display("mismatch at response %0d: %s got %0d, expected %0d",
               rsp_count, what, got, exp_val);
      fail_count++;
   endtask

   // Ring write, rank count over the whole window, then the gated filter move.
   function automatic filt_result_type predict_filter_step(logic [CHANNEL_W-1:0] ch,
                                                           logic signed [SAMPLE_W-1:0] s);
      filt_result_type   r;
      int                pos;
      int                above;
      int                below;
      logic signed [63:0] f;
      logic signed [63:0] target;
      logic signed [63:0] prod;
      r = '0;
      if (ch >= CHANNELS_DEF) return r;
      pos = wr_pos[ch] + 1;
      if (pos >= WINDOW_DEF) pos = 0;
      wr_pos[ch] = pos;
      win_mem[ch][pos] = s;
      above = 0;
      below = 0;
      for (int i = 0; i < WINDOW_DEF; i++) begin
         if (win_mem[ch][i] > s) above++;
         if (win_mem[ch][i] < s) below++;
      end
      r.accepted = (above < RANK_LIMIT) && (below < RANK_LIMIT);
      if (r.accepted) begin
         f      = filt_state[ch];
         target = s;
         target = target <<< FRAC_XTRA;
         prod   = (f - target) * $signed({48'd0, gain_copy});
         filt_state[ch] = f - (prod >>> 16);
      end
      // floor shift by the extra fraction bits
      r.filtered_temp = filt_state[ch][FILT_W-1:FRAC_XTRA];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS_DEF; c++) begin
            wr_pos[c]     = 0;
            filt_state[c] = '0;
            for (int i = 0; i < WINDOW_DEF; i++) win_mem[c][i] = '0;
         end
         gain_copy = GAIN_RESET;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("response with no request waiting", 0, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_filtered_temp !== want.filtered_temp)
                  report_mismatch("filtered_temp", rsp_filtered_temp, want.filtered_temp);
               if (rsp_accepted !== want.accepted)
                  report_mismatch("accepted", rsp_accepted, want.accepted);
            end
            rsp_count++;
         end
         if (csr_valid && csr_ready) gain_copy = csr_filter_gain;
         if (req_valid && req_ready)
            expected_q.push_back(predict_filter_step(req_channel, req_temp_sample));
      end
      pending = expected_q.size();
   end

endmodule

>>> dv/tb_rank_gated_lowpass_filter_core.sv
// Testbench top: clock, reset, request stimulus, gain writes and the verdict.
module tb_rank_gated_lowpass_filter_core;
   import rglf_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = WINDOW_DEF + 20;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic        [CHANNEL_W-1:0] req_channel = '0;
   logic signed [SAMPLE_W-1:0]  req_temp_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0]  rsp_filtered_temp;
   logic                       rsp_accepted;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic        [GAIN_W-1:0]    csr_filter_gain = '0;

   int fail_count;
   int pending;
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int chan_base [CHANNELS_DEF];

   always #5 clock = ~clock;

   rank_gated_lowpass_filter_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_channel       (req_channel),
      .req_temp_sample   (req_temp_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_filtered_temp (rsp_filtered_temp),
      .rsp_accepted      (rsp_accepted),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_filter_gain   (csr_filter_gain)
   );

   rglf_result_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_channel       (req_channel),
      .req_temp_sample   (req_temp_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_filtered_temp (rsp_filtered_temp),
      .rsp_accepted      (rsp_accepted),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_filter_gain   (csr_filter_gain),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   // any handshake resets the watchdog; the clearing pass after reset fits well inside
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake in %0d cycles", STALL_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a falling edge; returns at the falling edge after the request is taken
   task automatic send_sample(input logic [CHANNEL_W-1:0] ch,
                              input logic signed [SAMPLE_W-1:0] s);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_channel     <= ch;
      req_temp_sample <= s;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_gain(input logic [GAIN_W-1:0] g);
      drain();
      csr_valid       <= 1'b1;
      csr_filter_gain <= g;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly samples near the channel's temperature, some exact ties, some outliers
   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int base);
      int r;
      int v;
      r = $urandom_range(99);
      if (r < 10)      v = base;
      else if (r < 85) v = base + int'($urandom_range(400)) - 200;
      else             v = int'($urandom_range(65535)) - 32768;
      if (v > 32767)  v = 32767;
      if (v < -32768) v = -32768;
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic run_phase(input int n, input int idle, input int stall,
                            input bit extreme, input int pause_at);
      int ch;
      idle_pct  = idle;
      stall_pct = stall;
      for (int c = 0; c < CHANNELS_DEF; c++) begin
         if (extreme) chan_base[c] = (c == 0) ? 32700 : (c == 1) ? -32700 : 0;
         else         chan_base[c] = int'($urandom_range(9000)) - 3000;
      end
      for (int k = 0; k < n; k++) begin
         if (k == pause_at) drain();
         // a few requests go to the unused channel number
         if ($urandom_range(99) < 5) ch = 3;
         else                        ch = $urandom_range(CHANNELS_DEF - 1);
         send_sample(ch[CHANNEL_W-1:0], pick_sample((ch < CHANNELS_DEF) ? chan_base[ch] : 0));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_gain(16'hFFFF);
      send_sample(2'd3, 16'h7FFF);
      send_sample(2'd3, 16'h8000);
      send_sample(2'd0, 16'h0000);
      send_sample(2'd0, 16'h7FFF);
      send_sample(2'd0, 16'h8000);
      send_sample(2'd0, 16'hFFFF);
      send_sample(2'd0, 16'h0001);
      // the eleventh top-scale sample falls back into the middle quartiles
      for (int i = 0; i < 11; i++) send_sample(2'd1, 16'h7FFF);
      send_sample(2'd2, 16'h5555);
      send_sample(2'd2, 16'h0000);
      send_sample(2'd2, 16'hAAAA);

      write_gain(16'h0000);
      run_phase(200, 0, 0, 1'b0, -1);
      write_gain(GAIN_W'($urandom_range(65535)));
      run_phase(200, 87, 0, 1'b0, -1);
      write_gain(16'h0001);
      run_phase(200, 0, 87, 1'b1, -1);
      write_gain(GAIN_RESET);
      run_phase(230, 28, 28, 1'b0, -1);
      write_gain(GAIN_W'($urandom_range(65535)));
      run_phase(200, 0, 0, 1'b0, 100);

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> rank_gated_lowpass_filter_core.f
rtl/rglf_pkg.sv
rtl/rglf_ram.sv
rtl/rglf_rank.sv
rtl/rglf_update.sv
rtl/rank_gated_lowpass_filter_core.sv
rtl/rglf_check.sv
dv/rglf_result_checker.sv
dv/tb_rank_gated_lowpass_filter_core.sv
